// ----- hw/rtl/stg_pkg.sv -----
// Shared types, constants and the quarter-wave sine generator of the tone block.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package stg_pkg;

  // Default structural parameters
  localparam int unsigned TableBitsDef  = 10;
  localparam int unsigned FadeFramesDef = 128;
  localparam int unsigned SampleBitsDef = 16;

  // Fixed field widths
  localparam int unsigned PhaseW   = 32;
  localparam int unsigned FramesW  = 20;
  localparam int unsigned GainW    = 16;
  localparam int unsigned PcmW     = 16;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPhaseStep  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgToneFrames = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGain       = 2'd2;

  // Command queue depth (power of two)
  localparam int unsigned QueueDepth = 2;

  // Q30 fixed point for the table generator
  localparam logic [63:0] Q30One    = 64'd1 << 30;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Status that rides along with each command and sample
  typedef struct packed {
    logic active;
    logic last;
    logic neg;
  } flags_t;

  // One Horner step tail: clamp 1 - p at zero, Q30
  function automatic logic [63:0] q30_sub(input logic [63:0] p);
    return (p >= Q30One) ? 64'd0 : (Q30One - p);
  endfunction

  // Quarter-wave entry k of 2^(tbits-2) steps, rounded to full scale of sbits.
  // Only called with constant arguments, so it folds into a table.
  function automatic logic [63:0] quarter_sine(input int unsigned k,
                                               input int unsigned tbits,
                                               input int unsigned sbits);
    logic [63:0] fs;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    fs = (64'd1 << (sbits - 1)) - 64'd1;
    x  = (64'(k) * HalfPiQ30) >> (tbits - 2);
    x2 = (x * x) >> 30;
    t  = Q30One;
    t  = q30_sub(((x2 * t) >> 30) / 64'd156);
    t  = q30_sub(((x2 * t) >> 30) / 64'd110);
    t  = q30_sub(((x2 * t) >> 30) / 64'd72);
    t  = q30_sub(((x2 * t) >> 30) / 64'd42);
    t  = q30_sub(((x2 * t) >> 30) / 64'd20);
    t  = q30_sub(((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    v  = (s * fs + (Q30One >> 1)) >> 30;
    return (v > fs) ? fs : v;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/stg_front.sv -----
// Front end: accepts tick beats, tracks phase, frame count and run state,
// and classifies each beat into a sample command. Uses stg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stg_front #(
  parameter int unsigned SINE_TABLE_BITS = stg_pkg::TableBitsDef,
  parameter int unsigned FADE_LEN        = stg_pkg::FadeFramesDef,
  localparam int unsigned TW = SINE_TABLE_BITS - 1,
  localparam int unsigned NW = $clog2(FADE_LEN + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         start_tone_i,
  input  wire logic [stg_pkg::PhaseW-1:0]   phase_step_i,
  input  wire logic [stg_pkg::FramesW-1:0]  tone_frames_i,
  input  wire logic                         full_i,
  output logic                              push_o,
  output stg_pkg::flags_t                   flags_o,
  output logic [TW-1:0]                     tidx_o,
  output logic [NW-1:0]                     num_o
);

  localparam int unsigned FW     = stg_pkg::FramesW;
  localparam int unsigned MW     = SINE_TABLE_BITS - 2;
  localparam int unsigned QDepth = 2 ** (SINE_TABLE_BITS - 2);

  logic [stg_pkg::PhaseW-1:0] phase_q, phase_d, phase_cur;
  logic [FW-1:0]              frame_q, frame_d, frame_cur;
  logic                       running_q, running_d, run_cur;
  logic                       sound;
  logic                       is_last;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [MW-1:0]              m;
  logic [NW-1:0]              num;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // A start beat restarts phase and frame count before the beat is judged
  assign phase_cur = start_tone_i ? '0 : phase_q;
  assign frame_cur = start_tone_i ? '0 : frame_q;
  assign run_cur   = start_tone_i || running_q;

  assign sound = run_cur && (phase_step_i != '0) && (tone_frames_i != '0) &&
                 (frame_cur < tone_frames_i);
  assign is_last = (frame_cur == (tone_frames_i - FW'(1)));

  assign idx  = phase_cur[stg_pkg::PhaseW-1 -: SINE_TABLE_BITS];
  assign quad = idx[SINE_TABLE_BITS-1 -: 2];
  assign m    = idx[MW-1:0];

  // Linear envelope numerator: ramp up, flat, ramp down
  always_comb begin
    if (frame_cur < FW'(FADE_LEN)) begin
      num = NW'(frame_cur);
    end else if (({1'b0, frame_cur} + (FW+1)'(FADE_LEN)) > {1'b0, tone_frames_i}) begin
      num = NW'(tone_frames_i - frame_cur);
    end else begin
      num = NW'(FADE_LEN);
    end
  end

  always_comb begin
    flags_o.active = sound;
    flags_o.last   = sound && is_last;
    flags_o.neg    = quad[1];
    // Mirror odd quadrants onto the rising quarter
    tidx_o = quad[0] ? (TW'(QDepth) - TW'(m)) : TW'(m);
    num_o  = sound ? num : '0;
  end

  always_comb begin
    phase_d   = phase_q;
    frame_d   = frame_q;
    running_d = running_q;
    if (push_o) begin
      if (sound) begin
        phase_d   = phase_cur + phase_step_i;
        frame_d   = frame_cur + FW'(1);
        running_d = !is_last;
      end else begin
        phase_d   = phase_cur;
        frame_d   = frame_cur;
        running_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      frame_q   <= '0;
      running_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      frame_q   <= frame_d;
      running_q <= running_d;
    end
  end

  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && flags_o.last) |=> !running_q)
    else $error("run state survived the last frame");

  a_silent_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !flags_o.active) |-> (num_o == '0))
    else $error("silent beat carries a nonzero envelope");

endmodule

`default_nettype wire

// ----- hw/rtl/stg_fifo.sv -----
// Short command queue between front and back ends.
// Uses stg_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module stg_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = stg_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [Width-1:0]      data_o
);

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + PW'(1) : wr_q;
    rd_d  = pop_i  ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- hw/rtl/stg_back.sv -----
// Back end: sine lookup, envelope and gain scaling, divide by the fade
// length, sign and output register. Uses stg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stg_back #(
  parameter int unsigned SINE_TABLE_BITS = stg_pkg::TableBitsDef,
  parameter int unsigned FADE_LEN        = stg_pkg::FadeFramesDef,
  parameter int unsigned SAMPLE_BITS     = stg_pkg::SampleBitsDef,
  localparam int unsigned TW = SINE_TABLE_BITS - 1,
  localparam int unsigned NW = $clog2(FADE_LEN + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [stg_pkg::GainW-1:0]  gain_i,
  input  wire logic                       empty_i,
  input  wire stg_pkg::flags_t            flags_i,
  input  wire logic [TW-1:0]              tidx_i,
  input  wire logic [NW-1:0]              num_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [stg_pkg::PcmW-1:0]        pcm_sample_o,
  output logic                            tone_active_o,
  output logic                            last_frame_o
);

  localparam int unsigned GW     = stg_pkg::GainW;
  localparam int unsigned AW     = SAMPLE_BITS - 1;
  localparam int unsigned YW     = AW + NW;
  localparam int unsigned XW     = AW + stg_pkg::PcmW;
  localparam int unsigned QDepth = 2 ** (SINE_TABLE_BITS - 2);
  localparam logic [YW:0] Recip  = (YW+1)'((64'd1 << YW) / FADE_LEN);

  // Quarter-wave table, folded at elaboration
  logic [AW-1:0] rom_w [QDepth+1];
  for (genvar k = 0; k <= QDepth; k++) begin : g_rom
    assign rom_w[k] = AW'(stg_pkg::quarter_sine(k, SINE_TABLE_BITS, SAMPLE_BITS));
  end

  logic                     adv;
  logic [4:0]               vld_q;
  stg_pkg::flags_t          fl1_q, fl2_q, fl3_q, fl4_q, fl5_q, flo_q;
  logic [AW-1:0]            amp_q;
  logic [NW-1:0]            num1_q;
  logic [YW-1:0]            an_q;
  logic [YW+GW-1:0]         ang;
  logic [YW-1:0]            y3_q, y4_q;
  logic [2*YW:0]            qprod;
  logic [AW-1:0]            qe_q;
  logic [YW-1:0]            qf;
  logic [YW-1:0]            rem;
  logic [AW-1:0]            mag_q;
  logic [XW-1:0]            mag_x;
  logic [stg_pkg::PcmW-1:0] pcm_d, pcm_q;
  logic                     out_valid_q;

  // The whole pipe moves together unless a result waits at the output
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && !empty_i;

  // Quotient estimate and dividend enter stage four side by side
  assign ang   = an_q * gain_i;
  assign qprod = y3_q * Recip;
  assign qf    = YW'(qe_q * YW'(FADE_LEN));
  assign rem   = y4_q - qf;
  assign mag_x = XW'(mag_q);
  assign pcm_d = fl5_q.neg ? stg_pkg::PcmW'(XW'(0) - mag_x) : stg_pkg::PcmW'(mag_x);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      amp_q  <= rom_w[tidx_i];
      num1_q <= num_i;
      fl1_q  <= flags_i;
      an_q   <= YW'(amp_q * num1_q);
      fl2_q  <= fl1_q;
      y3_q   <= ang[YW+GW-1:GW];
      fl3_q  <= fl2_q;
      y4_q   <= y3_q;
      qe_q   <= qprod[YW +: AW];
      fl4_q  <= fl3_q;
      mag_q  <= qe_q + AW'(rem >= YW'(FADE_LEN));
      fl5_q  <= fl4_q;
      pcm_q  <= pcm_d;
      flo_q  <= fl5_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[3:0], pop_o};
      out_valid_q <= vld_q[4];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pcm_sample_o  = pcm_q;
  assign tone_active_o = flo_q.active;
  assign last_frame_o  = flo_q.last;

  a_silence_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tone_active_o) |-> (pcm_sample_o == '0))
    else $error("silent beat with nonzero sample");

  a_last_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_frame_o) |-> tone_active_o)
    else $error("last frame flagged on silence");

endmodule

`default_nettype wire

// ----- hw/rtl/sine_tone_generator_with_fade_top.sv -----
// Top level of the DDS sine tone generator with linear fade envelope.
// Holds the configuration registers; uses stg_pkg, stg_front, stg_fifo, stg_back.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  | Handshake              | Payload
//  ---------+------------------------+-----------------------------------------
//  tick in  | in_valid_i / in_ready_o | start_tone_i
//  sample   | out_valid_o/out_ready_i | pcm_sample_o, tone_active_o, last_frame_o
//  config   | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
//  One tick beat per cycle when samples are taken; the back pipe is six register
//  stages (table read, two multiplies, reciprocal multiply, correction, output).
//  Reset clears phase, frame count, run flag and all three config registers.
//  When the output register holds an untaken beat the back pipe halts as a
//  whole; the two-entry command queue lets the front take up to two more
//  ticks before in_ready_o drops.

module sine_tone_generator_with_fade_top #(
  parameter int unsigned SINE_TABLE_BITS = stg_pkg::TableBitsDef,
  parameter int unsigned FADE_LEN        = stg_pkg::FadeFramesDef,
  parameter int unsigned SAMPLE_BITS     = stg_pkg::SampleBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // tick input
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          start_tone_i,
  // sample output
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [stg_pkg::PcmW-1:0]           pcm_sample_o,
  output logic                               tone_active_o,
  output logic                               last_frame_o,
  // configuration writes
  input  wire logic                          cfg_we_i,
  input  wire logic [stg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [stg_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  localparam int unsigned TW = SINE_TABLE_BITS - 1;
  localparam int unsigned NW = $clog2(FADE_LEN + 1);
  localparam int unsigned FlW = $bits(stg_pkg::flags_t);
  localparam int unsigned CmdW = FlW + TW + NW;

  // Configuration registers
  logic [stg_pkg::PhaseW-1:0]  phase_step_q, phase_step_d;
  logic [stg_pkg::FramesW-1:0] tone_frames_q, tone_frames_d;
  logic [stg_pkg::GainW-1:0]   gain_q, gain_d;

  // Decode the write; indexes past the list are dropped
  always_comb begin
    phase_step_d  = phase_step_q;
    tone_frames_d = tone_frames_q;
    gain_d        = gain_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        stg_pkg::CfgPhaseStep:  phase_step_d  = cfg_wdata_i[stg_pkg::PhaseW-1:0];
        stg_pkg::CfgToneFrames: tone_frames_d = cfg_wdata_i[stg_pkg::FramesW-1:0];
        stg_pkg::CfgGain:       gain_d        = cfg_wdata_i[stg_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q  <= '0;
      tone_frames_q <= '0;
      gain_q        <= '0;
    end else begin
      phase_step_q  <= phase_step_d;
      tone_frames_q <= tone_frames_d;
      gain_q        <= gain_d;
    end
  end

  // Front: classify each tick and advance the oscillator state
  logic            push;
  logic            full;
  stg_pkg::flags_t f_flags;
  logic [TW-1:0]   f_tidx;
  logic [NW-1:0]   f_num;

  stg_front #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .FADE_LEN       (FADE_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_tone_i (start_tone_i),
    .phase_step_i (phase_step_q),
    .tone_frames_i(tone_frames_q),
    .full_i       (full),
    .push_o       (push),
    .flags_o      (f_flags),
    .tidx_o       (f_tidx),
    .num_o        (f_num)
  );

  // Queue: hold commands while the back pipe is stalled
  logic            pop;
  logic            empty;
  logic [CmdW-1:0] q_head;
  stg_pkg::flags_t b_flags;
  logic [TW-1:0]   b_tidx;
  logic [NW-1:0]   b_num;

  stg_fifo #(
    .Width(CmdW),
    .Depth(stg_pkg::QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({f_flags, f_tidx, f_num}),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (q_head)
  );

  assign {b_flags, b_tidx, b_num} = q_head;

  // Back: compute the scaled sample and hold it for the consumer
  stg_back #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS),
    .FADE_LEN       (FADE_LEN),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gain_i       (gain_q),
    .empty_i      (empty),
    .flags_i      (b_flags),
    .tidx_i       (b_tidx),
    .num_i        (b_num),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pcm_sample_o (pcm_sample_o),
    .tone_active_o(tone_active_o),
    .last_frame_o (last_frame_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb_sine_tone_generator_with_fade_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the DDS sine tone generator with linear fade envelope.
// Depends on stg_pkg and sine_tone_generator_with_fade_top; nothing else.

module tb_sine_tone_generator_with_fade_top;

  localparam int unsigned TableBits    = stg_pkg::TableBitsDef;
  localparam int unsigned FadeLen      = stg_pkg::FadeFramesDef;
  localparam int unsigned QuarterSteps = 1 << (TableBits - 2);
  localparam longint unsigned OneQ30   = 64'd1 << 30;
  localparam longint unsigned HalfPi   = 64'd1686629713;
  localparam longint unsigned PeakCode = (64'd1 << (stg_pkg::SampleBitsDef - 1)) - 64'd1;

  // Index 3 decodes to no register; writes to it must be dropped.
  localparam logic [stg_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;

  localparam int unsigned IdlePct     = 12;
  localparam int unsigned ItemTarget  = 1300;
  localparam int unsigned DrainCycles = 16;      // six-stage back pipe plus queue, with margin
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxRun      = 330;     // longest tick run in one setting

  typedef struct packed {
    logic [stg_pkg::PcmW-1:0] pcm;
    logic                     active;
    logic                     last;
  } sample_t;

  // DUT ports; every input starts at a known value.
  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_ready_o;
  logic                          start_tone_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i  = 1'b0;
  logic [stg_pkg::PcmW-1:0]      pcm_sample_o;
  logic                          tone_active_o;
  logic                          last_frame_o;
  logic                          cfg_we_i     = 1'b0;
  logic [stg_pkg::CfgIdxW-1:0]   cfg_idx_i    = '0;
  logic [stg_pkg::CfgDataW-1:0]  cfg_wdata_i  = '0;

  // Tone model: configuration copy and running state.
  logic [31:0] step_reg   = '0;
  logic [19:0] frames_reg = '0;
  logic [15:0] gain_reg   = '0;
  logic [31:0] phase      = '0;
  logic [19:0] frame_n    = '0;
  logic        sounding   = 1'b0;
  longint unsigned quarter_wave [0:QuarterSteps];

  logic    tick_q [$];        // start bits waiting to be driven
  sample_t due_samples [$];   // predicted samples not yet seen on the output
  logic    tick_taken = 1'b0; // tick beat accepted at the last rising edge
  logic    calm       = 1'b0; // no idling on either side while set

  int unsigned errors        = 0;
  int unsigned beats_checked = 0;
  int unsigned tones_done    = 0;
  int unsigned items_sent    = 0;
  int unsigned settings      = 0;
  int unsigned cycles        = 0;

  sine_tone_generator_with_fade_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_tone_i  (start_tone_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pcm_sample_o  (pcm_sample_o),
    .tone_active_o (tone_active_o),
    .last_frame_o  (last_frame_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Quarter-wave entry k in full-scale units: Q30 odd-power series of sin to
  // x^13 in Horner form, each step 1 - x^2*t/((2j+1)(2j)) clamped at zero.
  function automatic longint unsigned sine_entry(input int unsigned k);
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned acc;
    longint unsigned p;
    longint unsigned s;
    longint unsigned v;
    ang  = (64'(k) * HalfPi) / 64'(QuarterSteps);
    ang2 = (ang * ang) >> 30;
    acc  = OneQ30;
    for (int j = 6; j >= 1; j--) begin
      p   = ((ang2 * acc) >> 30) / 64'((2 * j + 1) * (2 * j));
      acc = (p >= OneQ30) ? 64'd0 : OneQ30 - p;
    end
    s = (ang * acc) >> 30;
    v = (s * PeakCode + (OneQ30 >> 1)) >> 30;
    return (v > PeakCode) ? PeakCode : v;
  endfunction

  // Advance the tone model by one tick and return the sample it should give.
  function automatic sample_t synth_tick(input logic start);
    sample_t          r;
    logic [TableBits-1:0] idx;
    logic [1:0]       quad;
    int unsigned      m;
    longint unsigned  num;
    longint unsigned  amp;
    longint unsigned  mag;
    r = '0;
    if (start) begin
      phase    = '0;
      frame_n  = '0;
      sounding = 1'b1;
    end
    if (sounding && step_reg != 0 && frames_reg != 0 && frame_n < frames_reg) begin
      // Linear envelope: ramp up, hold, ramp down over the last frames.
      if (frame_n < FadeLen)
        num = 64'(frame_n);
      else if (64'(frame_n) + 64'(FadeLen) > 64'(frames_reg))
        num = 64'(frames_reg - frame_n);
      else
        num = 64'(FadeLen);
      idx  = phase[31 -: TableBits];
      quad = idx[TableBits-1 -: 2];
      m    = 32'(idx[TableBits-3:0]);
      amp  = quad[0] ? quarter_wave[QuarterSteps - m] : quarter_wave[m];
      mag  = (amp * 64'(gain_reg) * num) / (64'd65536 * 64'(FadeLen));
      r.pcm    = quad[1] ? 16'(64'd0 - mag) : 16'(mag);
      r.active = 1'b1;
      r.last   = (frame_n == frames_reg - 20'd1);
      phase    = phase + step_reg;
      frame_n  = frame_n + 20'd1;
      if (r.last)
        sounding = 1'b0;
    end else begin
      sounding = 1'b0;
    end
    return r;
  endfunction

  task automatic check_field(input string what, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want_v, got_v);
    end
  endtask

  // Write one register while the block is idle and mirror it in the model.
  task automatic write_reg(input logic [stg_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      stg_pkg::CfgPhaseStep:  step_reg   = data;
      stg_pkg::CfgToneFrames: frames_reg = data[19:0];
      stg_pkg::CfgGain:       gain_reg   = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every tick went in and every predicted sample came out,
  // then let the pipe settle.
  task automatic wait_drained;
    while (!(tick_q.size() == 0 && !in_valid_i && due_samples.size() == 0))
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Queue a run of ticks: the first carries the given start bit, the rest
  // restart with the given chance. Then drain before the next setting.
  task automatic push_ticks(input logic first, input int unsigned len,
                            input int unsigned restart_pct);
    tick_q.push_back(first);
    for (int i = 1; i < len; i++)
      tick_q.push_back($urandom_range(0, 99) < restart_pct);
    items_sent += len;
    settings++;
    wait_drained();
  endtask

  // Driver: present the next tick at the falling edge once the current beat
  // was taken; idle now and then unless calm.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || tick_taken) begin
      if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
        in_valid_i   <= 1'b1;
        start_tone_i <= tick_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver backpressure: stall at random, never while calm.
  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= IdlePct);
  end

  // Monitor: check the sample beat first, then predict for the tick beat,
  // so a same-edge pair never depends on event order.
  always @(posedge clk_i) begin
    tick_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (due_samples.size() == 0) begin
          errors++;
          $display("%0t: sample beat with none expected, got pcm %0h active %b last %b",
                   $time, pcm_sample_o, tone_active_o, last_frame_o);
        end else begin
          sample_t exp_s;
          exp_s = due_samples.pop_front();
          check_field("pcm_sample", exp_s.pcm, pcm_sample_o);
          check_field("tone_active", exp_s.active, tone_active_o);
          check_field("last_frame", exp_s.last, last_frame_o);
          beats_checked++;
          if (exp_s.last)
            tones_done++;
        end
      end
      if (in_valid_i && in_ready_o)
        due_samples.push_back(synth_tick(start_tone_i));
    end
  end

  // Watchdog on a free-running cycle count.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("sine_tone_generator_with_fade_top regression: fail");
      $finish;
    end
  end

  initial begin : stim
    logic [31:0]  step_v;
    logic [31:0]  frames_v;
    logic [31:0]  gain_v;
    int unsigned  run_len;
    int unsigned  kind;

    for (int k = 0; k <= QuarterSteps; k++)
      quarter_wave[k] = sine_entry(k);

    // Hold reset, then release it away from the rising edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: registers still at reset, so every tick is silent.
    push_ticks(1'b1, 2, 0);
    // Half-turn step, three-frame tone at full gain: last frame, then silence.
    write_reg(stg_pkg::CfgPhaseStep, 32'h8000_0000);
    write_reg(stg_pkg::CfgToneFrames, 32'd3);
    write_reg(stg_pkg::CfgGain, 32'h0000_FFFF);
    push_ticks(1'b1, 4, 0);
    // Zero tuning word gives silence.
    write_reg(stg_pkg::CfgPhaseStep, 32'd0);
    write_reg(stg_pkg::CfgToneFrames, 32'd5);
    push_ticks(1'b1, 2, 0);
    // Zero tone length gives silence.
    write_reg(stg_pkg::CfgPhaseStep, 32'h4000_0000);
    write_reg(stg_pkg::CfgToneFrames, 32'd0);
    push_ticks(1'b1, 1, 0);
    // Widest values: phase wraps every tick, longest tone; spare index ignored.
    write_reg(stg_pkg::CfgPhaseStep, 32'hFFFF_FFFF);
    write_reg(stg_pkg::CfgToneFrames, 32'hFFFF_FFFF);
    write_reg(CfgSpare, 32'hFFFF_FFFF);
    push_ticks(1'b1, 6, 0);
    // Shorten the tone under a running frame count: silence, then a fresh tone.
    write_reg(stg_pkg::CfgToneFrames, 32'd2);
    push_ticks(1'b0, 2, 0);
    push_ticks(1'b1, 2, 0);
    // Zero gain with the smallest step.
    write_reg(stg_pkg::CfgGain, 32'd0);
    write_reg(stg_pkg::CfgPhaseStep, 32'd1);
    push_ticks(1'b1, 2, 0);

    // Random settings; mostly whole tones with random content, some noise.
    while (items_sent < ItemTarget) begin
      calm = (settings == 12);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       step_v = 32'd0;
          1:       step_v = 32'h8000_0000;
          2:       step_v = 32'hFFFF_FFFF;
          3:       step_v = $urandom_range(1, 255);
          default: step_v = $urandom;
        endcase
        write_reg(stg_pkg::CfgPhaseStep, step_v);
      end
      if ($urandom_range(0, 3) != 0) begin
        frames_v = $urandom;
        case ($urandom_range(0, 11))
          0:       frames_v[19:0] = 20'd0;
          1:       frames_v[19:0] = 20'd1;
          2:       frames_v[19:0] = 20'(FadeLen);
          3:       frames_v[19:0] = 20'(FadeLen + 1);
          4:       frames_v[19:0] = 20'hFFFFF;
          5:       frames_v[19:0] = 20'(2 * FadeLen);
          6:       frames_v[19:0] = 20'($urandom_range(2, FadeLen));
          default: frames_v[19:0] = 20'($urandom_range(2, 300));
        endcase
        write_reg(stg_pkg::CfgToneFrames, frames_v);
      end
      if ($urandom_range(0, 3) != 0) begin
        gain_v = $urandom;
        case ($urandom_range(0, 7))
          0:       gain_v[15:0] = 16'd0;
          1:       gain_v[15:0] = 16'hFFFF;
          default: ;
        endcase
        write_reg(stg_pkg::CfgGain, gain_v);
      end
      if ($urandom_range(0, 9) == 0)
        write_reg(CfgSpare, $urandom);
      // One long tone with both sides streaming flat out.
      if (calm) begin
        write_reg(stg_pkg::CfgPhaseStep, $urandom | 32'd1);
        write_reg(stg_pkg::CfgToneFrames, 32'd300);
      end

      run_len = int'(frames_reg) + $urandom_range(1, 3);
      if (run_len > MaxRun)
        run_len = $urandom_range(MaxRun / 2, MaxRun);
      kind = calm ? 9 : $urandom_range(0, 9);
      case (kind)
        0:       push_ticks(1'b0, $urandom_range(1, 20), 0);           // carry on, no restart
        1:       push_ticks(1'($urandom_range(0, 1)), $urandom_range(1, 40), 30); // noise
        2:       push_ticks(1'b1, run_len, 2);                          // restarts mid-tone
        default: push_ticks(1'b1, run_len, 0);                          // whole tone
      endcase
    end
    calm = 1'b0;

    wait_drained();
    $display("Checked %0d sample beats across %0d register settings;", beats_checked, settings);
    $display("%0d tones reached their last frame, %0d samples still owed.",
             tones_done, due_samples.size());
    if (errors == 0 && due_samples.size() == 0)
      $display("sine_tone_generator_with_fade_top regression: pass");
    else
      $display("sine_tone_generator_with_fade_top regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/stg_pkg.sv
hw/rtl/stg_front.sv
hw/rtl/stg_fifo.sv
hw/rtl/stg_back.sv
hw/rtl/sine_tone_generator_with_fade_top.sv
tb/tb_sine_tone_generator_with_fade_top.sv
